/* design/hkf_pkg.sv */
`timescale 1ns / 1ps

package hkf_pkg;

  typedef logic [1:0]  charset_t;
  typedef logic [15:0] code_t;

  localparam charset_t CS_ASCII = 2'd0;
  localparam charset_t CS_WIDE  = 2'd1;
  localparam charset_t CS_KANA  = 2'd2;

  localparam logic OP_CHAR  = 1'b0;
  localparam logic OP_FLUSH = 1'b1;

  localparam code_t KANA_FIRST  = 16'h0021;
  localparam code_t KANA_LAST   = 16'h005d;
  localparam code_t KANA_VOICED = 16'h005e;
  localparam code_t KANA_SEMI   = 16'h005f;
  localparam code_t ASCII_QMARK = 16'h003f;

  localparam code_t WIDE_U       = 16'h2526;
  localparam code_t WIDE_VU      = 16'h2574;
  localparam code_t WIDE_VOICED  = 16'h212b;
  localparam code_t WIDE_SEMI    = 16'h212c;
  localparam code_t WIDE_KA      = 16'h252b;
  localparam code_t WIDE_CHI     = 16'h2541;
  localparam code_t WIDE_TSU     = 16'h2544;
  localparam code_t WIDE_TO      = 16'h2548;
  localparam code_t WIDE_HA      = 16'h254f;
  localparam code_t WIDE_HI      = 16'h2552;
  localparam code_t WIDE_FU      = 16'h2555;
  localparam code_t WIDE_HE      = 16'h2558;
  localparam code_t WIDE_HO      = 16'h255b;

  localparam int KANA_ENTRIES = 61;
  localparam int KANA_IDX_W   = $clog2(KANA_ENTRIES);

  localparam code_t KANA_MAP [0:KANA_ENTRIES-1] = '{
    16'h2123, 16'h2156, 16'h2157, 16'h2122, 16'h2126, 16'h2572, 16'h2521, 16'h2523,
    16'h2525, 16'h2527, 16'h2529, 16'h2563, 16'h2565, 16'h2567, 16'h2543, 16'h213c,
    16'h2522, 16'h2524, 16'h2526, 16'h2528, 16'h252a, 16'h252b, 16'h252d, 16'h252f,
    16'h2531, 16'h2533, 16'h2535, 16'h2537, 16'h2539, 16'h253b, 16'h253d, 16'h253f,
    16'h2541, 16'h2544, 16'h2546, 16'h2548, 16'h254a, 16'h254b, 16'h254c, 16'h254d,
    16'h254e, 16'h254f, 16'h2552, 16'h2555, 16'h2558, 16'h255b, 16'h255e, 16'h255f,
    16'h2560, 16'h2561, 16'h2562, 16'h2564, 16'h2566, 16'h2568, 16'h2569, 16'h256a,
    16'h256b, 16'h256c, 16'h256d, 16'h256f, 16'h2573
  };

  // Caller guarantees KANA_FIRST <= code <= KANA_LAST
  function automatic code_t kana_lookup(input code_t code);
    code_t                 offs;
    logic [KANA_IDX_W-1:0] idx;
    offs = code - KANA_FIRST;
    idx  = offs[KANA_IDX_W-1:0];
    return KANA_MAP[idx];
  endfunction

  // HA, HI, FU, HE, HO
  function automatic logic is_ha_row(input code_t c);
    return (c == WIDE_HA) || (c == WIDE_HI) || (c == WIDE_FU) ||
           (c == WIDE_HE) || (c == WIDE_HO);
  endfunction

  // KA..CHI and TSU..TO on alternate codes, plus the HA row
  function automatic logic takes_voicing(input code_t c);
    logic ka_row;
    logic ta_row;
    ka_row = (c >= WIDE_KA) && (c <= WIDE_CHI) && c[0];
    ta_row = (c >= WIDE_TSU) && (c <= WIDE_TO) && !c[0];
    return ka_row || ta_row || is_ha_row(c);
  endfunction

endpackage

/* design/hkf_if.sv */
`timescale 1ns / 1ps

interface hkf_in_if;
  import hkf_pkg::*;

  logic     valid;
  logic     ready;
  logic     opcode;
  charset_t in_charset;
  code_t    in_code;

  modport source (output valid, output opcode, output in_charset, output in_code,
                  input ready);
  modport sink   (input valid, input opcode, input in_charset, input in_code,
                  output ready);
endinterface

interface hkf_out_if;
  import hkf_pkg::*;

  logic     valid;
  logic     ready;
  charset_t out_charset;
  code_t    out_code;

  modport source (output valid, output out_charset, output out_code, input ready);
  modport sink   (input valid, input out_charset, input out_code, output ready);
endinterface

/* design/halfwidth_kana_to_fullwidth_core.sv */
`timescale 1ns / 1ps

// Takes one item per cycle; in_if.ready drops only while the result register is
// full and out_if.ready is low.
// A character is held back until the next character or a flush pushes it out;
// the emitted result appears in the cycle after the transfer that releases it.
// Reset (rst_n low, synchronous) empties the hold and the result register.
module halfwidth_kana_to_fullwidth_core (
  input  logic     clk,
  input  logic     rst_n,
  hkf_in_if.sink   in_if,
  hkf_out_if.source out_if
);
  import hkf_pkg::*;

  logic     held_valid_r, held_valid_nxt;
  charset_t held_charset_r, held_charset_nxt;
  code_t    held_code_r, held_code_nxt;

  logic     out_valid_r, out_valid_nxt;
  charset_t out_charset_r, out_charset_nxt;
  code_t    out_code_r, out_code_nxt;

  logic     in_fire;
  logic     wide_held;
  logic     emit;
  charset_t conv_cs;
  code_t    conv_code;

  assign in_if.ready        = !out_valid_r || out_if.ready;
  assign in_fire            = in_if.valid && in_if.ready;
  assign out_if.valid       = out_valid_r;
  assign out_if.out_charset = out_charset_r;
  assign out_if.out_code    = out_code_r;

  assign wide_held = held_valid_r && (held_charset_r == CS_WIDE);

  always_comb begin
    held_valid_nxt   = held_valid_r;
    held_charset_nxt = held_charset_r;
    held_code_nxt    = held_code_r;
    emit             = 1'b0;
    conv_cs          = in_if.in_charset;
    conv_code        = in_if.in_code;

    if (in_fire) begin
      if (in_if.opcode == OP_FLUSH) begin
        emit             = held_valid_r;
        held_valid_nxt   = 1'b0;
        held_charset_nxt = CS_ASCII;
        held_code_nxt    = '0;
      end else begin
        emit = held_valid_r;
        if (in_if.in_charset == CS_KANA) begin
          priority if (in_if.in_code >= KANA_FIRST && in_if.in_code <= KANA_LAST) begin
            conv_cs   = CS_WIDE;
            conv_code = kana_lookup(in_if.in_code);
          end else if (in_if.in_code == KANA_VOICED) begin
            conv_cs   = CS_WIDE;
            conv_code = WIDE_VOICED;
          end else if (in_if.in_code == KANA_SEMI) begin
            conv_cs   = CS_WIDE;
            conv_code = WIDE_SEMI;
          end else begin
            conv_cs   = CS_ASCII;
            conv_code = ASCII_QMARK;
          end
        end
        held_valid_nxt   = 1'b1;
        held_charset_nxt = conv_cs;
        held_code_nxt    = conv_code;

        // sound marks that the held wide syllable can take fold into it and emit nothing
        if (in_if.in_charset == CS_KANA && wide_held) begin
          if (in_if.in_code == KANA_VOICED) begin
            if (held_code_r == WIDE_U) begin
              emit             = 1'b0;
              held_charset_nxt = held_charset_r;
              held_code_nxt    = WIDE_VU;
            end else if (takes_voicing(held_code_r)) begin
              emit             = 1'b0;
              held_charset_nxt = held_charset_r;
              held_code_nxt    = held_code_r + 16'd1;
            end
          end else if (in_if.in_code == KANA_SEMI && is_ha_row(held_code_r)) begin
            emit             = 1'b0;
            held_charset_nxt = held_charset_r;
            held_code_nxt    = held_code_r + 16'd2;
          end
        end
      end
    end

    out_valid_nxt   = out_valid_r && !out_if.ready;
    out_charset_nxt = out_charset_r;
    out_code_nxt    = out_code_r;
    if (emit) begin
      out_valid_nxt   = 1'b1;
      out_charset_nxt = held_charset_r;
      out_code_nxt    = held_code_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      held_valid_r   <= 1'b0;
      held_charset_r <= CS_ASCII;
      held_code_r    <= '0;
      out_valid_r    <= 1'b0;
    end else begin
      held_valid_r   <= held_valid_nxt;
      held_charset_r <= held_charset_nxt;
      held_code_r    <= held_code_nxt;
      out_valid_r    <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    out_charset_r <= out_charset_nxt;
    out_code_r    <= out_code_nxt;
  end

endmodule
